@@ sv/buc_pkg.sv @@
package buc_pkg;

   localparam int DEF_MAP_BYTES  = 32;
   localparam int DEF_UNIT_BYTES = 16;

   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;

   // reciprocal shift for offset / UNIT_BYTES; exact for offsets below 2**DIV_SHIFT / 256
   localparam int DIV_SHIFT = 24;

   localparam logic [7:0] MAP_FULL  = 8'hff;
   localparam logic [7:0] MAP_MSB   = 8'h80;
   localparam logic [7:0] MAP_EMPTY = 8'h00;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic                cmd;
      logic [OFFSET_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] alloc_offset;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

@@ sv/buc_map_ram.sv @@
module buc_map_ram #(
   parameter int DEPTH = buc_pkg::DEF_MAP_BYTES
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [7:0]                            wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [7:0]                            rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/buc_unit_div.sv @@
// unit index = offset / UNIT_BYTES by multiplying with a rounded-up reciprocal
module buc_unit_div #(
   parameter int MAP_BYTES  = buc_pkg::DEF_MAP_BYTES,
   parameter int UNIT_BYTES = buc_pkg::DEF_UNIT_BYTES
) (
   input  logic                                              clock,
   input  logic                                              load,
   input  logic [buc_pkg::OFFSET_W-1:0]                      offset,
   output logic [(MAP_BYTES > 1 ? $clog2(MAP_BYTES) : 1)+2:0] unit
);

   localparam int AW     = MAP_BYTES > 1 ? $clog2(MAP_BYTES) : 1;
   localparam int UNIT_W = AW + 3;
   localparam int RW     = buc_pkg::DIV_SHIFT + 1;
   localparam int PW     = buc_pkg::OFFSET_W + RW;
   localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << buc_pkg::DIV_SHIFT) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));

   logic [PW-1:0]     prod;
   logic [UNIT_W-1:0] unit_ff;
   logic [UNIT_W-1:0] unit_in;

   always_comb begin
      prod    = PW'(offset) * PW'(RECIP);
      unit_in = load ? prod[buc_pkg::DIV_SHIFT +: UNIT_W] : unit_ff;
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
   end

   assign unit = unit_ff;

endmodule

@@ sv/bitmap_unit_allocator_core.sv @@
// From accepted start to rsp_valid: an allocate scans from map byte 0 and answers at the byte
// holding the first free unit, or with STATUS_FULL after the last byte; a free reads, then
// writes its map byte; an out-of-range free answers STATUS_RANGE without a write. One item
// at a time; the map is scanned one byte per cycle through the RAM read port. busy drops with
// the result strobe, so the next start is taken at the edge ending the strobe. Synchronous
// reset, then every map byte is cleared with busy high; results cannot be stalled.
module bitmap_unit_allocator_core #(
   parameter int MAP_BYTES  = buc_pkg::DEF_MAP_BYTES,
   parameter int UNIT_BYTES = buc_pkg::DEF_UNIT_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  buc_pkg::req_type req_payload,
   output logic             rsp_valid,
   output buc_pkg::rsp_type rsp_payload
);

   localparam int AW     = MAP_BYTES > 1 ? $clog2(MAP_BYTES) : 1;
   localparam int UNIT_W = AW + 3;
   localparam int MW     = UNIT_W + 9;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);
   localparam logic [31:0]   POOL      = 32'(MAP_BYTES * 8 * UNIT_BYTES);

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      SCAN,
      FREE_RD,
      FREE_WR
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    chk_addr_ff, chk_addr_in;
   logic             chk_vld_ff, chk_vld_in;
   logic             in_range_ff, in_range_in;
   logic             rsp_valid_ff, rsp_valid_in;
   buc_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic [AW-1:0]    ram_rd_addr;
   logic [7:0]       ram_rd_data;
   logic [UNIT_W-1:0] free_unit;
   logic [2:0]       first_clear;
   logic [7:0]       alloc_mask;
   logic [MW-1:0]    alloc_prod;

   assign accept = start && (state_ff == IDLE);

   buc_map_ram #(
      .DEPTH (MAP_BYTES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   buc_unit_div #(
      .MAP_BYTES  (MAP_BYTES),
      .UNIT_BYTES (UNIT_BYTES)
   ) u_unit_div (
      .clock  (clock),
      .load   (accept),
      .offset (req_payload.free_offset),
      .unit   (free_unit)
   );

   // first clear bit counted from the MSB
   always_comb begin
      first_clear = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!ram_rd_data[7 - i]) begin
            first_clear = 3'(i);
         end
      end
      alloc_mask = buc_pkg::MAP_MSB >> first_clear;
      alloc_prod = MW'({chk_addr_ff, first_clear}) * MW'(UNIT_BYTES);
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      chk_addr_in  = chk_addr_ff;
      chk_vld_in   = 1'b0;
      in_range_in  = in_range_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = buc_pkg::MAP_EMPTY;
      ram_rd_addr  = addr_ff;

      unique case (state_ff)
         CLEAR: begin
            ram_wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         IDLE: begin
            if (accept) begin
               addr_in     = '0;
               in_range_in = 32'(req_payload.free_offset) < POOL;
               state_in    = (req_payload.cmd == buc_pkg::CMD_FREE) ? FREE_RD : SCAN;
            end
         end
         SCAN: begin
            // reads run one address ahead of the check
            chk_vld_in  = 1'b1;
            chk_addr_in = addr_ff;
            if (addr_ff != LAST_ADDR) begin
               addr_in = addr_ff + 1'b1;
            end
            if (chk_vld_ff && ram_rd_data != buc_pkg::MAP_FULL) begin
               ram_wr_en           = 1'b1;
               ram_wr_addr         = chk_addr_ff;
               ram_wr_data         = ram_rd_data | alloc_mask;
               rsp_valid_in        = 1'b1;
               rsp_in.alloc_offset = alloc_prod[buc_pkg::OFFSET_W-1:0];
               rsp_in.status       = buc_pkg::STATUS_OK;
               chk_vld_in          = 1'b0;
               state_in            = IDLE;
            end else if (chk_vld_ff && chk_addr_ff == LAST_ADDR) begin
               rsp_valid_in        = 1'b1;
               rsp_in.alloc_offset = '0;
               rsp_in.status       = buc_pkg::STATUS_FULL;
               chk_vld_in          = 1'b0;
               state_in            = IDLE;
            end
         end
         FREE_RD: begin
            ram_rd_addr = free_unit[UNIT_W-1:3];
            if (in_range_ff) begin
               state_in = FREE_WR;
            end else begin
               rsp_valid_in        = 1'b1;
               rsp_in.alloc_offset = '0;
               rsp_in.status       = buc_pkg::STATUS_RANGE;
               state_in            = IDLE;
            end
         end
         FREE_WR: begin
            ram_wr_en           = 1'b1;
            ram_wr_addr         = free_unit[UNIT_W-1:3];
            ram_wr_data         = ram_rd_data & ~(buc_pkg::MAP_MSB >> free_unit[2:0]);
            rsp_valid_in        = 1'b1;
            rsp_in.alloc_offset = '0;
            rsp_in.status       = buc_pkg::STATUS_OK;
            state_in            = IDLE;
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         addr_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_addr_ff <= chk_addr_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

   assign busy        = (state_ff != IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transfer in progress");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != buc_pkg::STATUS_OK) |-> rsp_payload.alloc_offset == '0)
      else $error("nonzero offset on failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == buc_pkg::STATUS_OK ||
                     rsp_payload.status == buc_pkg::STATUS_FULL ||
                     rsp_payload.status == buc_pkg::STATUS_RANGE))
      else $error("undefined status code");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff != IDLE)
      else $error("map written while idle");
`endif

endmodule
